### rtl/core/nrsp_pkg.sv
package nrsp_pkg;

	localparam int FIELD_CHARS_DEF = 16;
	localparam int MAX_LINE_DEF    = 128;
	localparam int NUM_DATA        = 5;
	localparam int CHUNK_CHARS     = 8;
	localparam int NUM_ROWS        = 2 * NUM_DATA;
	localparam int ROW_W           = 4;
	localparam int SLOT_W          = 3;

	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(NUM_ROWS - 1);
	localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(NUM_DATA);

	// header match progress
	localparam logic [2:0] HDR_HUNT  = 3'd0;
	localparam logic [2:0] HDR_FIRST = 3'd1;
	localparam logic [2:0] HDR_ALT   = 3'd2;
	localparam logic [2:0] HDR_LAST  = 3'd6;
	localparam logic [2:0] HDR_BODY  = 3'd7;

	localparam logic [2:0] FNUM_STATUS = 3'd1;
	localparam logic [2:0] FNUM_MAX    = 3'd7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_V      = 8'h56;

	typedef enum logic [1:0] {
		ST_TAKE,
		ST_READ,
		ST_SEND
	} nrsp_state_t;

	typedef struct packed {
		logic             accept;
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
	} nrsp_cmd_t;

	typedef struct packed {
		logic run_start;
	} nrsp_sts_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd1: ch = CH_G;
			3'd2: ch = CH_P;
			3'd3: ch = CH_R;
			3'd4: ch = CH_M;
			3'd5: ch = CH_C;
			3'd6: ch = CH_COMMA;
			default: ch = CH_DOLLAR;
		endcase
		return ch;
	endfunction

	// comma count to data slot, SLOT_NONE when not kept
	function automatic logic [SLOT_W-1:0] data_slot(input logic [2:0] fnum);
		logic [SLOT_W-1:0] s;
		case (fnum)
			3'd0: s = SLOT_W'(0);
			3'd2: s = SLOT_W'(1);
			3'd3: s = SLOT_W'(2);
			3'd4: s = SLOT_W'(3);
			3'd5: s = SLOT_W'(4);
			default: s = SLOT_NONE;
		endcase
		return s;
	endfunction

endpackage

### rtl/core/nrsp_ctrl.sv
module nrsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  nrsp_pkg::nrsp_sts_t sts,
	output nrsp_pkg::nrsp_cmd_t cmd
);
	import nrsp_pkg::*;

	nrsp_state_t      state_q, state_d;
	logic [ROW_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		in_stall   = 1'b1;
		out_valid  = 1'b0;
		cmd.accept = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.rd_row = idx_q;
		case (state_q)
			ST_TAKE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && sts.run_start) begin
					idx_d   = '0;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (idx_q == LAST_ROW) begin
						idx_d   = '0;
						state_d = ST_TAKE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_TAKE;
			end
		endcase
	end

	a_no_take_while_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during result run");

	a_hold_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(idx_q)))
		else $error("result row moved while stalled");

	a_read_then_send: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> (state_q == ST_SEND))
		else $error("read not followed by send");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && idx_q == LAST_ROW) |=> (state_q == ST_TAKE && idx_q == '0))
		else $error("run did not end after last result");

endmodule

### rtl/core/nrsp_datapath.sv
module nrsp_datapath #(
	parameter int FIELD_CHARS = nrsp_pkg::FIELD_CHARS_DEF,
	parameter int MAX_LINE    = nrsp_pkg::MAX_LINE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          rx_byte,
	input  nrsp_pkg::nrsp_cmd_t cmd,
	output nrsp_pkg::nrsp_sts_t sts,
	output logic [63:0]         chunk_chars,
	output logic [3:0]          char_count,
	output logic                fix_valid
);
	import nrsp_pkg::*;

	localparam int FLEN_W = $clog2(FIELD_CHARS + 1);
	localparam int LINE_W = $clog2(MAX_LINE + 1);

	logic [2:0]        hdr_q, hdr_d;
	logic [2:0]        fnum_q, fnum_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic [FLEN_W-1:0] cur_q, cur_d;
	logic [7:0]        stat_q, stat_d;
	logic              taken_q, taken_d;
	logic              cr_q, cr_d;
	logic              fix_q, fix_d;
	logic              clr_len, wr_en;
	logic [SLOT_W-1:0] slot;
	logic [5:0]        cur_ext;

	logic [FLEN_W-1:0] flen_q [NUM_DATA];
	logic [63:0]       mem_q  [NUM_ROWS];
	logic [63:0]       rd_data_q;
	logic [3:0]        cnt_q;
	logic [5:0]        len_ext;
	logic [3:0]        cnt_d;

	assign slot    = data_slot(fnum_q);
	assign cur_ext = 6'(cur_q);

	always_comb begin
		hdr_d         = hdr_q;
		fnum_d        = fnum_q;
		line_d        = line_q;
		cur_d         = cur_q;
		stat_d        = stat_q;
		taken_d       = taken_q;
		cr_d          = cr_q;
		fix_d         = fix_q;
		clr_len       = 1'b0;
		wr_en         = 1'b0;
		sts.run_start = 1'b0;
		if (cmd.accept) begin
			if (rx_byte == CH_DOLLAR) begin
				hdr_d  = HDR_FIRST;
				line_d = LINE_W'(1);
				cr_d   = 1'b0;
			end else if (hdr_q != HDR_HUNT) begin
				if (line_q >= LINE_W'(MAX_LINE)) begin
					hdr_d = HDR_HUNT;
					cr_d  = 1'b0;
				end else begin
					line_d = line_q + 1'b1;
					if (hdr_q != HDR_BODY) begin
						if (!(rx_byte == hdr_char(hdr_q) ||
						      (hdr_q == HDR_ALT && rx_byte == CH_N))) begin
							hdr_d = HDR_HUNT;
							cr_d  = 1'b0;
						end else if (hdr_q == HDR_LAST) begin
							hdr_d   = HDR_BODY;
							fnum_d  = '0;
							cur_d   = '0;
							clr_len = 1'b1;
							stat_d  = '0;
							taken_d = 1'b0;
							cr_d    = 1'b0;
						end else begin
							hdr_d = hdr_q + 3'd1;
						end
					end else if (cr_q && rx_byte == CH_LF) begin
						hdr_d         = HDR_HUNT;
						cr_d          = 1'b0;
						sts.run_start = 1'b1;
						if (taken_q && stat_q == CH_A) begin
							fix_d = 1'b1;
						end else if (taken_q && stat_q == CH_V) begin
							fix_d = 1'b0;
						end
					end else begin
						cr_d = 1'b0;
						if (rx_byte == CH_CR) begin
							cr_d = 1'b1;
						end else if (rx_byte == CH_COMMA) begin
							if (fnum_q < FNUM_MAX) begin
								fnum_d = fnum_q + 3'd1;
							end
							cur_d = '0;
						end else if (fnum_q == FNUM_STATUS) begin
							if (!taken_q) begin
								stat_d  = rx_byte;
								taken_d = 1'b1;
							end
						end else if (slot != SLOT_NONE && cur_q < FLEN_W'(FIELD_CHARS)) begin
							wr_en = 1'b1;
							cur_d = cur_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= HDR_HUNT;
			fnum_q  <= '0;
			line_q  <= '0;
			cur_q   <= '0;
			stat_q  <= '0;
			taken_q <= 1'b0;
			cr_q    <= 1'b0;
			fix_q   <= 1'b0;
			for (int i = 0; i < NUM_DATA; i++) begin
				flen_q[i] <= '0;
			end
		end else begin
			hdr_q   <= hdr_d;
			fnum_q  <= fnum_d;
			line_q  <= line_d;
			cur_q   <= cur_d;
			stat_q  <= stat_d;
			taken_q <= taken_d;
			cr_q    <= cr_d;
			fix_q   <= fix_d;
			if (clr_len) begin
				for (int i = 0; i < NUM_DATA; i++) begin
					flen_q[i] <= '0;
				end
			end else if (wr_en) begin
				flen_q[slot] <= cur_q + 1'b1;
			end
		end
	end

	// character store, one row per 8-character chunk
	always_ff @(posedge clk) begin
		if (wr_en && cur_ext < 6'(2 * CHUNK_CHARS)) begin
			mem_q[{slot, cur_q[3]}][{cur_q[2:0], 3'b000} +: 8] <= rx_byte;
		end
	end

	assign len_ext = 6'(flen_q[cmd.rd_row[ROW_W-1:1]]);

	always_comb begin
		if (!cmd.rd_row[0]) begin
			cnt_d = (len_ext > 6'd8) ? 4'd8 : len_ext[3:0];
		end else if (len_ext > 6'd16) begin
			cnt_d = 4'd8;
		end else if (len_ext > 6'd8) begin
			cnt_d = 4'(len_ext - 6'd8);
		end else begin
			cnt_d = 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[cmd.rd_row];
			cnt_q     <= cnt_d;
		end
	end

	always_comb begin
		for (int i = 0; i < CHUNK_CHARS; i++) begin
			chunk_chars[i*8 +: 8] = (4'(i) < cnt_q) ? rd_data_q[i*8 +: 8] : 8'h00;
		end
	end

	assign char_count = cnt_q;
	assign fix_valid  = fix_q;

endmodule

### rtl/core/nmea_rmc_sentence_parser_unit.sv
// RMC sentence parser
//
// Input channel: one received character per request on rx_byte, taken when
// in_valid is high and in_stall is low. Outside a result run the block
// takes one character every cycle.
// Output channel: after a "$GPRMC," or "$GNRMC," line ends in CR LF the block
// sends ten results, UTC time, latitude, N/S, longitude and E/W, each as two
// 8-character chunks with a count, the updated fix flag, and last_of_run on
// the tenth. in_stall stays high for the whole run.
// Sequencing: after the LF is taken the block reads a row of the character
// store into a register, then presents it as a result; once that result is
// taken it reads the next row, so each result follows a registered read of
// the store. After the tenth result is taken it returns to taking characters.
// When out_stall is high the current result holds and the run waits.
// Reset clears the header match, field counts and the fix flag; the
// character store is not cleared and holds no request after reset.
module nmea_rmc_sentence_parser_unit #(
	parameter int FIELD_CHARS = nrsp_pkg::FIELD_CHARS_DEF,
	parameter int MAX_LINE    = nrsp_pkg::MAX_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  field_id,
	output logic        chunk_index,
	output logic [63:0] chunk_chars,
	output logic [3:0]  char_count,
	output logic        fix_valid,
	output logic        last_of_run
);
	import nrsp_pkg::*;

	nrsp_cmd_t cmd;
	nrsp_sts_t sts;

	nrsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nrsp_datapath #(
		.FIELD_CHARS (FIELD_CHARS),
		.MAX_LINE    (MAX_LINE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.sts         (sts),
		.chunk_chars (chunk_chars),
		.char_count  (char_count),
		.fix_valid   (fix_valid)
	);

	assign field_id    = cmd.rd_row[ROW_W-1:1];
	assign chunk_index = cmd.rd_row[0];
	assign last_of_run = (cmd.rd_row == LAST_ROW);

endmodule

### test/nmea_rmc_sentence_parser_unit_checker.sv
module nmea_rmc_sentence_parser_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  field_id,
	input  logic        chunk_index,
	input  logic [63:0] chunk_chars,
	input  logic [3:0]  char_count,
	input  logic        fix_valid,
	input  logic        last_of_run,
	output int          mismatch_count,
	output int          chunks_pending
);
	import nrsp_pkg::*;

	localparam int FCH  = FIELD_CHARS_DEF;
	localparam int MAXL = MAX_LINE_DEF;
	localparam logic [55:0] RMC_HDR = {CH_COMMA, CH_C, CH_M, CH_R, CH_P, CH_G, CH_DOLLAR};

	typedef struct packed {
		logic [2:0]  fid;
		logic        cidx;
		logic [63:0] chars;
		logic [3:0]  cnt;
		logic        fix;
		logic        last;
	} rmc_chunk_t;

	rmc_chunk_t  chunk_q[$];
	logic [2:0]  hdr_pos;
	logic [2:0]  comma_cnt;
	int          fld_len[NUM_DATA];
	logic [7:0]  fld_chars[NUM_DATA*FCH];
	int          line_len;
	logic [7:0]  status_ch;
	logic        status_seen;
	logic        cr_seen;
	logic        fix_flag;
	int          err_cnt;

	task automatic clear_fields();
		comma_cnt = '0;
		for (int f = 0; f < NUM_DATA; f++) fld_len[f] = 0;
		status_ch = '0;
		status_seen = 1'b0;
		cr_seen = 1'b0;
	endtask

	// sentence end: update the fix flag and queue the ten chunks
	task automatic push_run();
		rmc_chunk_t ch;
		int n;
		if (status_seen) begin
			if (status_ch == CH_A) fix_flag = 1'b1;
			else if (status_ch == CH_V) fix_flag = 1'b0;
		end
		for (int f = 0; f < NUM_DATA; f++) begin
			for (int c = 0; c < 2; c++) begin
				n = fld_len[f] - CHUNK_CHARS * c;
				if (n < 0) n = 0;
				if (n > CHUNK_CHARS) n = CHUNK_CHARS;
				ch.fid = 3'(f);
				ch.cidx = 1'(c);
				ch.chars = '0;
				for (int i = 0; i < n; i++)
					ch.chars[8*i +: 8] = fld_chars[f*FCH + CHUNK_CHARS*c + i];
				ch.cnt = 4'(n);
				ch.fix = fix_flag;
				ch.last = (f == NUM_DATA - 1) && (c == 1);
				chunk_q.push_back(ch);
			end
		end
	endtask

	task automatic parse_body(input logic [7:0] b);
		logic ended;
		int slot;
		ended = 1'b0;
		if (cr_seen) begin
			cr_seen = 1'b0;
			if (b == CH_LF) begin
				hdr_pos = HDR_HUNT;
				push_run();
				ended = 1'b1;
			end
		end
		if (!ended) begin
			if (b == CH_CR) begin
				cr_seen = 1'b1;
			end else if (b == CH_COMMA) begin
				if (comma_cnt < FNUM_MAX) comma_cnt = comma_cnt + 3'd1;
			end else if (comma_cnt == FNUM_STATUS) begin
				if (!status_seen) begin
					status_ch = b;
					status_seen = 1'b1;
				end
			end else begin
				// time, latitude, N/S, longitude, E/W; later fields dropped
				if (comma_cnt == 3'd0) slot = 0;
				else if (comma_cnt >= 3'd2 && comma_cnt <= 3'd5) slot = int'(comma_cnt) - 1;
				else slot = NUM_DATA;
				if (slot < NUM_DATA && fld_len[slot] < FCH) begin
					fld_chars[slot*FCH + fld_len[slot]] = b;
					fld_len[slot]++;
				end
			end
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic ok;
		if (b == CH_DOLLAR) begin
			hdr_pos = HDR_FIRST;
			line_len = 1;
			cr_seen = 1'b0;
		end else if (hdr_pos != HDR_HUNT) begin
			if (line_len + 1 > MAXL) begin
				hdr_pos = HDR_HUNT;
				cr_seen = 1'b0;
			end else begin
				line_len++;
				if (hdr_pos != HDR_BODY) begin
					ok = (b == RMC_HDR[8*hdr_pos +: 8]) || (hdr_pos == HDR_ALT && b == CH_N);
					if (!ok) begin
						hdr_pos = HDR_HUNT;
						cr_seen = 1'b0;
					end else if (hdr_pos == HDR_LAST) begin
						hdr_pos = HDR_BODY;
						clear_fields();
					end else begin
						hdr_pos = hdr_pos + 3'd1;
					end
				end else begin
					parse_body(b);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	task automatic check_chunk();
		rmc_chunk_t exp;
		if (chunk_q.size() == 0) begin
			$error("unexpected result: field_id %0d chunk_index %0d", field_id, chunk_index);
			err_cnt++;
		end else begin
			exp = chunk_q.pop_front();
			check_field("field_id", 64'(exp.fid), 64'(field_id));
			check_field("chunk_index", 64'(exp.cidx), 64'(chunk_index));
			check_field("chunk_chars", exp.chars, chunk_chars);
			check_field("char_count", 64'(exp.cnt), 64'(char_count));
			check_field("fix_valid", 64'(exp.fix), 64'(fix_valid));
			check_field("last_of_run", 64'(exp.last), 64'(last_of_run));
		end
	endtask

	initial begin
		err_cnt = 0;
		mismatch_count = 0;
		chunks_pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos = HDR_HUNT;
			clear_fields();
			for (int i = 0; i < NUM_DATA*FCH; i++) fld_chars[i] = '0;
			line_len = 0;
			fix_flag = 1'b0;
			chunk_q.delete();
		end else begin
			if (in_valid && !in_stall) parse_byte(rx_byte);
			if (out_valid && !out_stall) check_chunk();
			mismatch_count <= err_cnt;
			chunks_pending <= chunk_q.size();
		end
	end

endmodule

### test/nmea_rmc_sentence_parser_unit_test.sv
module nmea_rmc_sentence_parser_unit_test;
	import nrsp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  field_id;
	logic        chunk_index;
	logic [63:0] chunk_chars;
	logic [3:0]  char_count;
	logic        fix_valid;
	logic        last_of_run;

	int          mismatch_count;
	int          chunks_pending;
	int          cycle_count = 0;
	int          rand_bytes;
	logic        idle_en = 1'b1;
	logic        long_hold_req = 1'b0;
	logic        hold_done = 1'b0;
	logic [7:0]  line_q[$];

	nmea_rmc_sentence_parser_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_id    (field_id),
		.chunk_index (chunk_index),
		.chunk_chars (chunk_chars),
		.char_count  (char_count),
		.fix_valid   (fix_valid),
		.last_of_run (last_of_run)
	);

	nmea_rmc_sentence_parser_unit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.field_id       (field_id),
		.chunk_index    (chunk_index),
		.chunk_chars    (chunk_chars),
		.char_count     (char_count),
		.fix_valid      (fix_valid),
		.last_of_run    (last_of_run),
		.mismatch_count (mismatch_count),
		.chunks_pending (chunks_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 25)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_line();
		while (line_q.size() != 0) begin
			send_byte(line_q.pop_front());
			rand_bytes++;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		line_q.push_back(b);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	task automatic push_end();
		line_q.push_back(CH_CR);
		line_q.push_back(CH_LF);
	endtask

	task automatic push_fill(input int n, input logic [7:0] ch);
		for (int i = 0; i < n; i++) line_q.push_back(ch);
	endtask

	function automatic logic [7:0] rand_char();
		string charset;
		logic [7:0] b;
		charset = "0123456789.ABCDEFGHIJKLMNOPQRSTUVWXYZ-";
		if ($urandom_range(0, 99) < 90) begin
			b = charset[$urandom_range(0, charset.len() - 1)];
		end else begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_DOLLAR) b = 8'h23;
		end
		return b;
	endfunction

	task automatic push_field(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 3) push_byte(CH_CR);
			push_byte(rand_char());
		end
	endtask

	task automatic build_sentence();
		int nfld;
		int hdr_at;
		int r;
		for (int i = $urandom_range(0, 3); i > 0; i--) push_byte(8'($urandom_range(0, 255)));
		hdr_at = line_q.size();
		if ($urandom_range(0, 1)) push_str("$GPRMC,");
		else push_str("$GNRMC,");
		if ($urandom_range(0, 99) < 12)
			line_q[hdr_at + $urandom_range(1, 6)] = 8'($urandom_range(0, 255));
		nfld = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 6) : 12;
		for (int k = 0; k < nfld; k++) begin
			if (k > 0) push_byte(CH_COMMA);
			case (k)
				1: begin
					r = $urandom_range(0, 5);
					if (r < 2) push_byte(CH_A);
					else if (r < 4) push_byte(CH_V);
					else if (r == 5) push_field($urandom_range(1, 3));
				end
				3, 5: push_field($urandom_range(0, 2));
				0, 2, 4: push_field(($urandom_range(0, 99) < 12) ?
					$urandom_range(11, 20) : $urandom_range(0, 10));
				default: push_field($urandom_range(0, 6));
			endcase
		end
		if ($urandom_range(0, 99) < 3) push_field(100);
		r = $urandom_range(0, 99);
		if (r < 85) begin
			push_end();
		end else if (r < 90) begin
			push_byte(CH_CR);
		end else if (r < 95) begin
			push_byte(CH_LF);
		end
	endtask

	initial begin
		rand_bytes = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise outside a sentence, byte extremes
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_str("GPRMC,1,A");
		push_end();
		// full sentence, active fix
		push_str("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4*6A");
		push_end();
		// lone CRs and bare LF inside fields
		push_str("$GPRMC,12");
		push_byte(CH_CR);
		push_str("34,A,");
		push_byte(CH_CR);
		push_str("5,N");
		push_byte(CH_CR);
		push_end();
		push_str("$GPRMC,1");
		push_byte(CH_LF);
		push_str(",A");
		push_end();
		// dollar restarts
		push_str("$GPR$GPRMC,1,A");
		push_end();
		push_str("$GPRMC,12,V,3$GNRMC,9,V");
		push_end();
		// extreme bytes stored in a field
		push_str("$GNRMC,");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_str(",A,");
		push_byte(8'hFE);
		push_str(",N");
		push_end();
		send_line();

		while (rand_bytes < 230) begin
			if (rand_bytes >= 200) idle_en = 1'b0;
			if (!hold_done && rand_bytes >= 120) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			build_sentence();
			send_line();
		end
		idle_en = 1'b0;
		// line of exactly the maximum
		push_str("$GPRMC,");
		push_fill(MAX_LINE_DEF - 9, 8'h37);
		push_end();
		send_line();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chunks_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && chunks_pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### nmea_rmc_sentence_parser_unit.f
rtl/core/nrsp_pkg.sv
rtl/core/nrsp_ctrl.sv
rtl/core/nrsp_datapath.sv
rtl/core/nmea_rmc_sentence_parser_unit.sv
test/nmea_rmc_sentence_parser_unit_checker.sv
test/nmea_rmc_sentence_parser_unit_test.sv
